### rtl/core/min_max_contiguous_partition_unit_assert.svh
// assertion macros for the min-max contiguous partition unit
`ifndef MIN_MAX_CONTIGUOUS_PARTITION_UNIT_ASSERT_SVH
`define MIN_MAX_CONTIGUOUS_PARTITION_UNIT_ASSERT_SVH

// same-cycle implication
`define MMCP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmcp assertion failed");

// next-cycle implication
`define MMCP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmcp assertion failed");

`endif

### rtl/core/mmcp_pkg.sv
// package of the min-max contiguous partition unit: constants, types, microcode rom
`default_nettype none

package mmcp_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned WEIGHT_W  = 20;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = ADDR_W + 1;
  localparam int unsigned LOAD_W    = WEIGHT_W + ADDR_W;
  localparam int unsigned SUM_W     = LOAD_W + 1;
  localparam int unsigned GROUP_W   = 11;
  localparam int unsigned PADDR_W   = 2;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [PADDR_W-1:0] ADDR_PART_COUNT = 2'd0;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CHECK,
    STEP_LOOP,
    STEP_ISSUE,
    STEP_ACC,
    STEP_DONE
  } step_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_INIT,
    OP_PROBE,
    OP_READ,
    OP_ACC,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_START_LAST,
    COND_SKIP,
    COND_LO_GE_HI,
    COND_PROBE_END
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e target;
    step_e next;
  } ucode_t;

  typedef struct packed {
    logic start_last;
    logic skip;
    logic lo_ge_hi;
    logic probe_end;
  } seq_status_t;

  function automatic ucode_t ucode_rom(input step_e step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:  w = '{op: OP_LOAD,  cond: COND_START_LAST, target: STEP_CHECK,
                        next: STEP_IDLE};
      STEP_CHECK: w = '{op: OP_INIT,  cond: COND_SKIP,       target: STEP_DONE,
                        next: STEP_LOOP};
      STEP_LOOP:  w = '{op: OP_PROBE, cond: COND_LO_GE_HI,   target: STEP_DONE,
                        next: STEP_ISSUE};
      STEP_ISSUE: w = '{op: OP_READ,  cond: COND_NONE,       target: STEP_ACC,
                        next: STEP_ACC};
      STEP_ACC:   w = '{op: OP_ACC,   cond: COND_PROBE_END,  target: STEP_LOOP,
                        next: STEP_ISSUE};
      STEP_DONE:  w = '{op: OP_EMIT,  cond: COND_NONE,       target: STEP_IDLE,
                        next: STEP_IDLE};
      default:    w = '{op: OP_LOAD,  cond: COND_NONE,       target: STEP_IDLE,
                        next: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/mmcp_store.sv
// item weight store: one write port, one registered read port
`default_nettype none

module mmcp_store (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [mmcp_pkg::ADDR_W-1:0]   waddr_i,
  input  wire logic [mmcp_pkg::WEIGHT_W-1:0] wdata_i,
  input  wire logic                          re_i,
  input  wire logic [mmcp_pkg::ADDR_W-1:0]   raddr_i,
  output logic      [mmcp_pkg::WEIGHT_W-1:0] rdata_o
);

  logic [mmcp_pkg::WEIGHT_W-1:0] mem_q [mmcp_pkg::MAX_ITEMS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/mmcp_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module mmcp_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mmcp_pkg::seq_status_t status_i,
  output mmcp_pkg::ucode_t           ctrl_o
);

  mmcp_pkg::step_e step_q, step_d;
  logic            take;

  always_comb begin
    ctrl_o = mmcp_pkg::ucode_rom(step_q);
  end

  always_comb begin
    unique case (ctrl_o.cond)
      mmcp_pkg::COND_NONE:       take = 1'b0;
      mmcp_pkg::COND_START_LAST: take = status_i.start_last;
      mmcp_pkg::COND_SKIP:       take = status_i.skip;
      mmcp_pkg::COND_LO_GE_HI:   take = status_i.lo_ge_hi;
      mmcp_pkg::COND_PROBE_END:  take = status_i.probe_end;
      default:                   take = 1'b0;
    endcase
    step_d = take ? ctrl_o.target : ctrl_o.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mmcp_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/min_max_contiguous_partition_unit.sv
// Min-max contiguous partition unit. Weights are loaded with start_i/busy_o, one
// transfer per cycle while busy_o is low; an item without last_item_i leaves busy_o low.
// The item with last_item_i starts a binary search between the largest and the total
// weight; busy_o stays high until the result. Each probe is a greedy pass over the
// stored items through the single read port of the item store, each item visited
// being read and then accumulated; up to about 30 probes for full-range weights.
// Overflowed or infeasible sequences skip the search. The result appears for
// exactly one cycle with result_valid_o and must be taken then: the receiver cannot
// stall. part_count is written over APB (register at byte address 0) by the user
// only while idle, which the block does not enforce; zero counts as one group.
`default_nettype none

`include "min_max_contiguous_partition_unit_assert.svh"

module min_max_contiguous_partition_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [mmcp_pkg::WEIGHT_W-1:0]       page_count_i,
  input  wire logic                                last_item_i,
  output logic                                     result_valid_o,
  output logic      [mmcp_pkg::LOAD_W-1:0]         min_max_load_o,
  output logic                                     feasible_o,
  output logic                                     overflow_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mmcp_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [mmcp_pkg::PDATA_W-1:0]        pwdata,
  output logic      [mmcp_pkg::PDATA_W-1:0]        prdata,
  output logic                                     pready
);

  mmcp_pkg::ucode_t      ctrl;
  mmcp_pkg::seq_status_t status;

  logic [mmcp_pkg::GROUP_W-1:0]  part_count_q;
  logic [mmcp_pkg::GROUP_W-1:0]  groups;
  logic [mmcp_pkg::CNT_W-1:0]    total_q, total_d;
  logic [mmcp_pkg::LOAD_W-1:0]   sum_q, sum_d;
  logic [mmcp_pkg::WEIGHT_W-1:0] peak_q, peak_d;
  logic                          ovf_q, ovf_d;
  logic                          ok_q, ok_d;
  logic [mmcp_pkg::LOAD_W-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, run_q, run_d;
  logic [mmcp_pkg::CNT_W-1:0]    used_q, used_d;
  logic [mmcp_pkg::ADDR_W-1:0]   idx_q, idx_d;
  logic [mmcp_pkg::WEIGHT_W-1:0] rdata;
  logic                          accept, has_room, mem_we, mem_re, ok_now;
  logic [mmcp_pkg::SUM_W-1:0]    run_sum;
  logic                          over, fail, last_idx;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == mmcp_pkg::ADDR_PART_COUNT) ?
                  mmcp_pkg::PDATA_W'(part_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q <= mmcp_pkg::GROUP_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      part_count_q <= pwdata[mmcp_pkg::GROUP_W-1:0];
    end
  end

  assign groups = (part_count_q == '0) ? mmcp_pkg::GROUP_W'(1) : part_count_q;

  mmcp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  mmcp_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (total_q[mmcp_pkg::ADDR_W-1:0]),
    .wdata_i (page_count_i),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign busy_o         = (ctrl.op != mmcp_pkg::OP_LOAD);
  assign accept         = start_i && !busy_o;
  assign has_room       = (total_q < mmcp_pkg::CNT_W'(mmcp_pkg::MAX_ITEMS));
  assign mem_we         = accept && has_room;
  assign mem_re         = (ctrl.op == mmcp_pkg::OP_READ);
  assign ok_now         = (total_q >= mmcp_pkg::CNT_W'(groups));

  // greedy pass arithmetic
  assign run_sum  = mmcp_pkg::SUM_W'(run_q) + mmcp_pkg::SUM_W'(rdata);
  assign over     = (run_sum > mmcp_pkg::SUM_W'(mid_q));
  assign fail     = over && (used_q >= mmcp_pkg::CNT_W'(groups));
  assign last_idx = ((mmcp_pkg::CNT_W'(idx_q) + mmcp_pkg::CNT_W'(1)) == total_q);

  assign status.start_last = accept && last_item_i;
  assign status.skip       = !ok_now || ovf_q;
  assign status.lo_ge_hi   = (lo_q >= hi_q);
  assign status.probe_end  = fail || last_idx;

  assign result_valid_o = (ctrl.op == mmcp_pkg::OP_EMIT);
  assign min_max_load_o = (ok_q && !ovf_q) ? lo_q : '0;
  assign feasible_o     = ok_q;
  assign overflow_o     = ovf_q;

  always_comb begin
    total_d = total_q;
    sum_d   = sum_q;
    peak_d  = peak_q;
    ovf_d   = ovf_q;
    ok_d    = ok_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    run_d   = run_q;
    used_d  = used_q;
    idx_d   = idx_q;
    unique case (ctrl.op)
      mmcp_pkg::OP_LOAD: begin
        if (accept) begin
          if (has_room) begin
            total_d = total_q + mmcp_pkg::CNT_W'(1);
            sum_d   = sum_q + mmcp_pkg::LOAD_W'(page_count_i);
            if (page_count_i > peak_q) begin
              peak_d = page_count_i;
            end
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      mmcp_pkg::OP_INIT: begin
        ok_d = ok_now;
        lo_d = mmcp_pkg::LOAD_W'(peak_q);
        hi_d = sum_q;
      end
      mmcp_pkg::OP_PROBE: begin
        mid_d  = lo_q + ((hi_q - lo_q) >> 1);
        run_d  = '0;
        used_d = mmcp_pkg::CNT_W'(1);
        idx_d  = '0;
      end
      mmcp_pkg::OP_READ: begin
      end
      mmcp_pkg::OP_ACC: begin
        if (over) begin
          run_d  = mmcp_pkg::LOAD_W'(rdata);
          used_d = used_q + mmcp_pkg::CNT_W'(1);
        end else begin
          run_d  = run_sum[mmcp_pkg::LOAD_W-1:0];
        end
        idx_d = idx_q + mmcp_pkg::ADDR_W'(1);
        if (fail) begin
          lo_d = mid_q + mmcp_pkg::LOAD_W'(1);
        end else if (last_idx) begin
          hi_d = mid_q;
        end
      end
      mmcp_pkg::OP_EMIT: begin
        total_d = '0;
        sum_d   = '0;
        peak_d  = '0;
        ovf_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      sum_q   <= '0;
      peak_q  <= '0;
      ovf_q   <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      total_q <= total_d;
      sum_q   <= sum_d;
      peak_q  <= peak_d;
      ovf_q   <= ovf_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    run_q  <= run_d;
    used_q <= used_d;
    idx_q  <= idx_d;
  end

  // search runs between the last item and its result
  `MMCP_ASSERT_NEXT(a_last_starts_search, clk_i, rst_ni, accept && last_item_i, busy_o)
  `MMCP_ASSERT_NEXT(a_plain_item_stays_idle, clk_i, rst_ni, accept && !last_item_i, !busy_o)
  `MMCP_ASSERT_NEXT(a_result_then_idle, clk_i, rst_ni, result_valid_o, !busy_o && !overflow_o)
  `MMCP_ASSERT_NOW(a_infeasible_zero_load, clk_i, rst_ni, result_valid_o && (!feasible_o || overflow_o), min_max_load_o == '0)

endmodule

`default_nettype wire
